// File: hdl/projective_point_transform_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the projective point transform unit
// Clocked implication checks, same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_POINT_TRANSFORM_UNIT_ASSERT_SVH
`define PROJECTIVE_POINT_TRANSFORM_UNIT_ASSERT_SVH

// same-cycle implication
`define PPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppt: assertion failed");

// next-cycle implication
`define PPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ppt: assertion failed");

`endif

// File: hdl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Word types, register indexes and reset values of the point transform.
// ----------------------------------------------------------------------------
package ppt_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               zero_denominator;
        logic               saturated;
    } t_point_out;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_XX_XY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XZ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YX_YY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YZ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZX_ZY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZZ    = 3'd5;

    localparam logic [63:0] RST_XX_XY = 64'h0001_0000_0000_0000;
    localparam logic [31:0] RST_XZ    = 32'h0000_0000;
    localparam logic [63:0] RST_YX_YY = 64'h0000_0000_0001_0000;
    localparam logic [31:0] RST_YZ    = 32'h0000_0000;
    localparam logic [63:0] RST_ZX_ZY = 64'h0000_0000_0000_0000;
    localparam logic [31:0] RST_ZZ    = 32'h0001_0000;

endpackage

// File: hdl/ppt_stream_if.sv
// ----------------------------------------------------------------------------
// ppt_stream_if
// Valid/ready stream channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface ppt_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/projective_point_transform_unit.sv
// ----------------------------------------------------------------------------
// projective_point_transform_unit
// 3x3 homography on one Q16.16 point per word, with saturation.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output buffer has room; the
//   33-step restoring divider (one quotient bit per stage, x and y side by
//   side) sets the depth. Reset: synchronous, active low; clears stage
//   valids and the output buffer and loads the coefficient registers with their reset values.
`include "projective_point_transform_unit_assert.svh"

module projective_point_transform_unit
    import ppt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ppt_stream_if.sink           i_pt,
    ppt_stream_if.source         o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);

    // stage map: 0 products, 1 product sum, 2 constant term, 3 magnitudes,
    // 4 divider setup, 5..37 one quotient bit each (bit 32 down to bit 0)
    localparam int QB   = 33;          // quotient bits kept
    localparam int NSTG = 5 + QB;      // registered stages ahead of the buffer
    localparam int RW   = 80;          // dividend register width (n << 16)
    localparam int CW   = RW + QB - 16 + 1; // compare width for d << k

    typedef struct packed {
        logic signed [63:0] xa, xb, ya, yb, za, zb;
        logic               affine;
    } t_prod;

    typedef struct packed {
        logic signed [63:0] nx, ny, nd;
        logic               affine;
    } t_sum;

    typedef struct packed {
        logic [63:0]        mx, my, md;
        logic               negx, negy, zero, affine, asat;
        logic signed [31:0] ax, ay;
    } t_mag;

    typedef struct packed {
        logic [RW-1:0]      rx, ry;
        logic [QB-1:0]      qx, qy;
        logic [63:0]        md;
        logic               ovx, ovy, negx, negy, zero, affine, asat;
        logic signed [31:0] ax, ay;
    } t_div;

    // ---------------------------------------------------------------- config
    logic [63:0] r_xx_xy, r_yx_yy, r_zx_zy;
    logic [31:0] r_xz, r_yz, r_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xx_xy <= RST_XX_XY;
            r_xz    <= RST_XZ;
            r_yx_yy <= RST_YX_YY;
            r_yz    <= RST_YZ;
            r_zx_zy <= RST_ZX_ZY;
            r_zz    <= RST_ZZ;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_XX_XY: r_xx_xy <= i_cfg_data;
                REG_XZ:    r_xz    <= i_cfg_data[31:0];
                REG_YX_YY: r_yx_yy <= i_cfg_data;
                REG_YZ:    r_yz    <= i_cfg_data[31:0];
                REG_ZX_ZY: r_zx_zy <= i_cfg_data;
                REG_ZZ:    r_zz    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- helpers
    // clamp a 65-bit sum back into the signed 64-bit range
    function automatic logic signed [63:0] sat64(input logic signed [64:0] s);
        logic signed [63:0] v;
        if (s[64] != s[63]) begin
            v = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            v = s[63:0];
        end
        return v;
    endfunction

    // floor Q32.32 -> Q16.16 then clamp; result {sat, value}
    function automatic logic [32:0] floor_clamp(input logic signed [63:0] s);
        logic signed [63:0] f;
        logic [32:0]        r;
        f = s >>> 16;
        if (f > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (f < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, f[31:0]};
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // signed, saturated quotient; result {sat, value}
    function automatic logic [32:0] fin_q(input logic ov, input logic neg,
                                          input logic [QB-1:0] q);
        logic [32:0] r;
        if (neg) begin
            if (ov || q > QB'(33'h0_8000_0000)) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, 32'd0 - q[31:0]};
            end
        end else begin
            if (ov || q > QB'(33'h0_7FFF_FFFF)) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else begin
                r = {1'b0, q[31:0]};
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------- flow control
    // the whole pipe moves together while the two-word output buffer can
    // take what is in flight at the last stage
    logic [NSTG-1:0] r_v;
    logic [1:0]      r_cnt;
    logic            adv;

    assign adv        = (r_cnt != 2'd2) && !(r_cnt == 2'd1 && r_v[NSTG-1] && !o_res.ready);
    assign i_pt.ready = adv;

    // -------------------------------------------------------------- stage 0
    t_prod r_p;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p.xa     <= 64'(i_pt.data.point_x) * 64'($signed(r_xx_xy[63:32]));
            r_p.xb     <= 64'(i_pt.data.point_y) * 64'($signed(r_xx_xy[31:0]));
            r_p.ya     <= 64'(i_pt.data.point_x) * 64'($signed(r_yx_yy[63:32]));
            r_p.yb     <= 64'(i_pt.data.point_y) * 64'($signed(r_yx_yy[31:0]));
            r_p.za     <= 64'(i_pt.data.point_x) * 64'($signed(r_zx_zy[63:32]));
            r_p.zb     <= 64'(i_pt.data.point_y) * 64'($signed(r_zx_zy[31:0]));
            r_p.affine <= (r_zx_zy == 64'd0);
        end
    end

    // -------------------------------------------------------------- stage 1
    t_sum r_s1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1.nx     <= sat64(65'(r_p.xa) + 65'(r_p.xb));
            r_s1.ny     <= sat64(65'(r_p.ya) + 65'(r_p.yb));
            r_s1.nd     <= sat64(65'(r_p.za) + 65'(r_p.zb));
            r_s1.affine <= r_p.affine;
        end
    end

    // -------------------------------------------------------------- stage 2
    t_sum r_s2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2.nx     <= sat64(65'(r_s1.nx) + 65'($signed({r_xz, 16'd0})));
            r_s2.ny     <= sat64(65'(r_s1.ny) + 65'($signed({r_yz, 16'd0})));
            r_s2.nd     <= sat64(65'(r_s1.nd) + 65'($signed({r_zz, 16'd0})));
            r_s2.affine <= r_s1.affine;
        end
    end

    // -------------------------------------------------------------- stage 3
    t_mag        r_m;
    logic [32:0] afx, afy;
    assign afx = floor_clamp(r_s2.nx);
    assign afy = floor_clamp(r_s2.ny);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m.mx     <= mag64(r_s2.nx);
            r_m.my     <= mag64(r_s2.ny);
            r_m.md     <= mag64(r_s2.nd);
            r_m.negx   <= r_s2.nx[63] ^ r_s2.nd[63];
            r_m.negy   <= r_s2.ny[63] ^ r_s2.nd[63];
            r_m.zero   <= (r_s2.nd == 64'sd0);
            r_m.affine <= r_s2.affine;
            r_m.ax     <= afx[31:0];
            r_m.ay     <= afy[31:0];
            r_m.asat   <= afx[32] | afy[32];
        end
    end

    // ---------------------------------------------------------- divider
    // r_dv[0]: setup; quotient >= 2^33 is flagged as overflow up front
    t_div r_dv [0:QB];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv[0].rx     <= {r_m.mx, 16'd0};
            r_dv[0].ry     <= {r_m.my, 16'd0};
            r_dv[0].qx     <= '0;
            r_dv[0].qy     <= '0;
            r_dv[0].md     <= r_m.md;
            r_dv[0].ovx    <= {17'd0, r_m.mx} >= {r_m.md, 17'd0};
            r_dv[0].ovy    <= {17'd0, r_m.my} >= {r_m.md, 17'd0};
            r_dv[0].negx   <= r_m.negx;
            r_dv[0].negy   <= r_m.negy;
            r_dv[0].zero   <= r_m.zero;
            r_dv[0].affine <= r_m.affine;
            r_dv[0].asat   <= r_m.asat;
            r_dv[0].ax     <= r_m.ax;
            r_dv[0].ay     <= r_m.ay;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [CW-1:0] dk;
        t_div          n_dv;

        assign dk = CW'(r_dv[j].md) << K;

        always_comb begin
            n_dv = r_dv[j];
            if (CW'(r_dv[j].rx) >= dk) begin
                n_dv.rx    = r_dv[j].rx - dk[RW-1:0];
                n_dv.qx[K] = 1'b1;
            end
            if (CW'(r_dv[j].ry) >= dk) begin
                n_dv.ry    = r_dv[j].ry - dk[RW-1:0];
                n_dv.qy[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[j+1] <= n_dv;
            end
        end
    end

    // ------------------------------------------------------------ valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NSTG-2:0], i_pt.valid};
        end
    end

    // --------------------------------------------------------- result pick
    t_point_out  res;
    logic [32:0] fqx, fqy;
    assign fqx = fin_q(r_dv[QB].ovx, r_dv[QB].negx, r_dv[QB].qx);
    assign fqy = fin_q(r_dv[QB].ovy, r_dv[QB].negy, r_dv[QB].qy);

    always_comb begin
        if (r_dv[QB].affine) begin
            res.out_x            = r_dv[QB].ax;
            res.out_y            = r_dv[QB].ay;
            res.zero_denominator = 1'b0;
            res.saturated        = r_dv[QB].asat;
        end else if (r_dv[QB].zero) begin
            res.out_x            = '0;
            res.out_y            = '0;
            res.zero_denominator = 1'b1;
            res.saturated        = 1'b0;
        end else begin
            res.out_x            = fqx[31:0];
            res.out_y            = fqy[31:0];
            res.zero_denominator = 1'b0;
            res.saturated        = fqx[32] | fqy[32];
        end
    end

    // ------------------------------------------------------ output buffer
    // two-word buffer; lets the pipe keep moving while a result waits
    t_point_out r_q [0:1];
    logic       r_wp, r_rp;
    logic       push, pop;

    assign push = adv && r_v[NSTG-1];
    assign pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= res;
        end
    end

    assign o_res.valid = (r_cnt != 2'd0);
    assign o_res.data  = r_q[r_rp];

    // ---------------------------------------------------------- checks
    `PPT_ASSERT_IMP(a_zero_den_out, i_clk, i_rst_n, o_res.valid && o_res.data.zero_denominator, (o_res.data.out_x == 32'sd0) && (o_res.data.out_y == 32'sd0) && !o_res.data.saturated)
    `PPT_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_pt.valid && i_pt.ready, r_v[0])
    `PPT_ASSERT_IMP(a_no_overfill, i_clk, i_rst_n, r_cnt == 2'd2, !push || pop)

endmodule

// File: test/projective_point_transform_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point transform unit testbench
// Drives points through the 3x3 Q16.16 transform under several coefficient
// sets, predicts or takes a hand-typed result for every word and checks it
// field by field, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module projective_point_transform_unit_tb;
    import ppt_pkg::*;

    localparam int LATENCY   = 39;
    localparam int MAX_CYCLE = 400000;
    localparam int N_RANDOM  = 900;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [63:0]          i_cfg_data;

    ppt_stream_if #(.T(t_point_in))  pt_if ();
    ppt_stream_if #(.T(t_point_out)) res_if ();

    projective_point_transform_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // local copy of the coefficient registers
    logic [63:0] m_xx_xy, m_yx_yy, m_zx_zy;
    logic [31:0] m_xz, m_yz, m_zz;

    t_point_out expected_q[$];
    int         n_err;
    int         cycle;
    bit         hold_off;    // long output stall request
    bit         rx_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // -------------------------------------------------------------- predictor
    function automatic logic signed [63:0] add_sat64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        // overflow when operands share a sign the sum lacks
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic logic signed [63:0] dot3(logic signed [31:0] x,
                                                logic signed [31:0] y,
                                                logic signed [31:0] a,
                                                logic signed [31:0] b,
                                                logic signed [31:0] c);
        logic signed [63:0] px, py, cc;
        px = 64'(x) * 64'(a);
        py = 64'(y) * 64'(b);
        cc = 64'(c) <<< 16;
        return add_sat64(add_sat64(px, py), cc);
    endfunction

    function automatic logic [31:0] clip32(logic signed [63:0] v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [31:0] quot_q16(logic signed [63:0] num,
                                             logic signed [63:0] den,
                                             inout bit sat);
        logic [63:0] n, d, q, r;
        bit          neg;
        n   = abs64(num);
        d   = abs64(den);
        neg = num[63] != den[63];
        q   = n / d;
        r   = n % d;
        if (q > 64'd65536) q = 64'd65536;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        if (neg) begin
            if (q > 64'h8000_0000) begin
                sat = 1;
                return 32'h8000_0000;
            end
            return 32'(64'd0 - q);
        end
        if (q > 64'h7FFF_FFFF) begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic t_point_out transform_point(t_point_in p);
        t_point_out         r;
        logic signed [63:0] nx, ny, den;
        bit                 sat;
        sat = 0;
        r   = '0;
        nx  = dot3(p.point_x, p.point_y, m_xx_xy[63:32], m_xx_xy[31:0], m_xz);
        ny  = dot3(p.point_x, p.point_y, m_yx_yy[63:32], m_yx_yy[31:0], m_yz);
        if (m_zx_zy == 64'd0) begin
            // affine: floor shift back to Q16.16
            r.out_x = clip32(nx >>> 16, sat);
            r.out_y = clip32(ny >>> 16, sat);
        end else begin
            den = dot3(p.point_x, p.point_y, m_zx_zy[63:32], m_zx_zy[31:0], m_zz);
            if (den == 64'sd0) begin
                r.zero_denominator = 1'b1;
            end else begin
                r.out_x = quot_q16(nx, den, sat);
                r.out_y = quot_q16(ny, den, sat);
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    // ------------------------------------------------------------ config port
    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_XX_XY: m_xx_xy = val;
            REG_XZ:    m_xz    = val[31:0];
            REG_YX_YY: m_yx_yy = val;
            REG_YZ:    m_yz    = val[31:0];
            REG_ZX_ZY: m_zx_zy = val;
            REG_ZZ:    m_zz    = val[31:0];
            default: ;
        endcase
    endtask

    task automatic load_matrix(logic [63:0] xxy, logic [31:0] xz,
                               logic [63:0] yxy, logic [31:0] yz,
                               logic [63:0] zxy, logic [31:0] zz);
        write_coef(REG_XX_XY, xxy);
        write_coef(REG_XZ,    {32'(0), xz});
        write_coef(REG_YX_YY, yxy);
        write_coef(REG_YZ,    {32'(0), yz});
        write_coef(REG_ZX_ZY, zxy);
        write_coef(REG_ZZ,    {32'(0), zz});
    endtask

    // wait for the pipe to drain before touching the coefficients
    task automatic drain_pipe();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- sender
    task automatic send_point(t_point_in p, t_point_out fixed_exp, bit use_fixed);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.data  <= p;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        expected_q.push_back(use_fixed ? fixed_exp : transform_point(p));
        // valid stays up; next call lowers it only on a gap
    endtask

    task automatic idle_input();
        pt_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 8) << 16;
            3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 6))
            0: return 32'h0;
            1: return 32'h0001_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'($signed($urandom_range(0, 262144)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    // ----------------------------------------------------------- directed set
    typedef struct {
        t_point_in  pt;
        t_point_out res;
        bit         known;   // result typed in by hand
    } t_dir_row;

    t_dir_row dir_rows[$];

    task automatic add_row(logic [31:0] x, logic [31:0] y,
                           t_point_out r, bit known);
        t_dir_row row;
        row.pt.point_x = x;
        row.pt.point_y = y;
        row.res        = r;
        row.known      = known;
        dir_rows.push_back(row);
    endtask

    // ---------------------------------------------------------------- receiver
    always @(posedge i_clk) begin
        t_point_out got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (expected_q.size() == 0) begin
                n_err <= n_err + 1;
                if (n_err < 10) $display("unexpected result word %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                    got.zero_denominator !== want.zero_denominator ||
                    got.saturated !== want.saturated) begin
                    n_err <= n_err + 1;
                    if (n_err < 10)
                        $display("mismatch: exp x=%h y=%h z=%b s=%b got x=%h y=%h z=%b s=%b",
                                 want.out_x, want.out_y, want.zero_denominator,
                                 want.saturated, got.out_x, got.out_y,
                                 got.zero_denominator, got.saturated);
                end
            end
        end
    end

    // ready with random gaps and one long hold-off
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off && !rx_hold_done) begin
                res_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                rx_hold_done = 1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------- main
    initial begin
        t_point_out r;
        t_point_in  p;
        int         n_sent;
        hold_off     = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        pt_if.valid  = 1'b0;
        pt_if.data   = '0;
        m_xx_xy = RST_XX_XY; m_xz = RST_XZ; m_yx_yy = RST_YX_YY;
        m_yz    = RST_YZ;    m_zx_zy = RST_ZX_ZY; m_zz = RST_ZZ;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset matrix is identity: point passes through
        r = '0; r.out_x = 32'h7FFF_FFFF; r.out_y = 32'h8000_0000;
        add_row(32'h7FFF_FFFF, 32'h8000_0000, r, 1);
        r = '0;
        add_row(32'h0, 32'h0, r, 1);
        r.out_x = 32'h0001_8000; r.out_y = 32'hFFFF_0000;
        add_row(32'h0001_8000, 32'hFFFF_0000, r, 1);
        foreach (dir_rows[i])
            send_point(dir_rows[i].pt, dir_rows[i].res, dir_rows[i].known);
        idle_input();
        drain_pipe();
        dir_rows.delete();

        // extreme affine: max x-row and min y-row coefficients; the first point saturates both coordinates
        load_matrix({32'h7FFF_FFFF, 32'h7FFF_FFFF}, 32'h7FFF_FFFF,
                    {32'h8000_0000, 32'h8000_0000}, 32'h8000_0000, 64'd0, 32'h0);
        r = '0; r.out_x = 32'h7FFF_FFFF; r.out_y = 32'h8000_0000; r.saturated = 1'b1;
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, r, 1);
        add_row(32'h8000_0000, 32'h8000_0000, r, 0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, r, 0);
        add_row(32'h0000_0001, 32'hFFFF_FFFF, r, 0);
        foreach (dir_rows[i])
            send_point(dir_rows[i].pt, dir_rows[i].res, dir_rows[i].known);
        idle_input();
        drain_pipe();
        dir_rows.delete();

        // projective, zero denominator at origin (zz = 0)
        load_matrix({32'h0001_0000, 32'h0}, 32'h0003_0000,
                    {32'h0, 32'h0001_0000}, 32'hFFFE_0000,
                    {32'h0000_8000, 32'hFFFF_8000}, 32'h0);
        r = '0; r.zero_denominator = 1'b1;
        add_row(32'h0, 32'h0, r, 1);
        add_row(32'h0002_0000, 32'h0002_0000, r, 1);
        add_row(32'h0004_0000, 32'h0001_0000, r, 0);
        add_row(32'hFFFF_0000, 32'h0000_0001, r, 0);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, r, 0);
        add_row(32'h0000_0001, 32'h0, r, 0);
        foreach (dir_rows[i])
            send_point(dir_rows[i].pt, dir_rows[i].res, dir_rows[i].known);
        idle_input();
        drain_pipe();
        dir_rows.delete();

        // write to unused index must not change anything
        write_coef(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        write_coef(3'd6, 64'h1234_5678_9ABC_DEF0);

        // random part: new matrix every 100 points
        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            load_matrix({rand_coef(), rand_coef()}, rand_coef(),
                        {rand_coef(), rand_coef()}, rand_coef(),
                        ($urandom_range(0, 2) == 0) ? 64'd0 : {rand_coef(), rand_coef()},
                        rand_coef());
            if (n_sent == 300) hold_off = 1;
            for (int k = 0; k < 100; k++) begin
                p.point_x = rand_q16();
                p.point_y = rand_q16();
                send_point(p, '0, 0);
                n_sent++;
            end
            idle_input();
            drain_pipe();
        end

        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
